// File: design/point_segment_distance_3d_core_defines.svh
// ----------------------------------------------------------------------------
// Point-segment distance core: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_CORE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_CORE_DEFINES_SVH

// same-cycle implication
`define PSD_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSD_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/psd_pkg.sv
// ----------------------------------------------------------------------------
// Point-segment distance package
// Widths, case codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int CRD_W  = 24;
    localparam int DIFF_W = 25;
    localparam int PRD_W  = 50;
    localparam int DOT_W  = 52;
    localparam int REM_W  = 51;
    localparam int DEN_W  = 50;
    localparam int RAT_W  = 24;
    localparam int OFS_W  = 27;
    localparam int MAG_W  = 26;
    localparam int SQ_W   = 52;
    localparam int SQS_W  = 54;
    localparam int ROOT_W = 27;
    localparam int RR_W   = 31;
    localparam int DIST_W = 25;
    localparam int IN_W   = 9 * CRD_W;
    localparam int OUT_W  = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        CASE_A   = 2'd0,
        CASE_B   = 2'd1,
        CASE_MID = 2'd2
    } t_case;

    typedef logic [2:0][DIFF_W-1:0] t_vec;

    typedef struct packed {
        t_case            kind;
        logic [DOT_W-1:0] c1;
        logic [DOT_W-1:0] c2;
        t_vec             w;
        t_vec             v;
        t_vec             u;
    } t_job;

endpackage

// File: design/point_segment_distance_3d_core.sv
// ----------------------------------------------------------------------------
// Point-segment distance core, top level
// Shortest distance from a 3D point to a segment, fixed point, streamed.
// ----------------------------------------------------------------------------
// Slave beat: tdata packs query x/y/z, start x/y/z, end x/y/z (24-bit signed
// Q15.8 each), query_x in the lowest bits. Master beat: tdata[24:0] carries
// the Q17.8 distance, saturated; tuser[1:0] carries the nearest-point case
// (A, B or interior).
// Throughput is one beat per cycle while the receiver keeps tready high. With
// no stall a beat passes four front stages, one queue slot, 24 divider stages
// for the projection ratio, five offset and square stages, 27 root stages, and
// the output register.
// The front end and back end each stall on their own and the job queue
// (QUEUE_DEPTH entries) sits between them. When the receiver holds tready
// low the back pipeline freezes, the queue fills, and then tready on the
// slave side drops. Synchronous reset empties all pipelines and the queue;
// no beat is in flight after reset.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // query_x, query_y, query_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [psd_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // distance, zero pad
    output logic [psd_pkg::OUT_W-1:0]   o_m_tdata,
    // nearest_case
    output logic [1:0]                  o_m_tuser
);

    logic                        w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    psd_pkg::t_job               w_f_job, w_q_job;
    logic [psd_pkg::DIST_W-1:0]  w_dist;
    psd_pkg::t_case              w_case;

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_job   (w_f_job)
    );

    psd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_job   (w_f_job),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_job   (w_q_job)
    );

    psd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_job      (w_q_job),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_distance (w_dist),
        .o_case     (w_case)
    );

    assign o_m_tdata = {{(psd_pkg::OUT_W - psd_pkg::DIST_W){1'b0}}, w_dist};
    assign o_m_tuser = w_case;

endmodule

// File: design/psd_front.sv
// ----------------------------------------------------------------------------
// Point-segment distance front end
// Differences, dot products and case classification, four stages.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [psd_pkg::IN_W-1:0]    i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output psd_pkg::t_job               o_job
);

    logic                r_v1, r_v2, r_v3, r_v4;
    psd_pkg::t_vec       r_w1, r_v1d, r_u1, n_w1, n_v1d, n_u1;
    psd_pkg::t_vec       r_w2, r_vd2, r_u2;
    psd_pkg::t_vec       r_w3, r_vd3, r_u3;
    logic signed [psd_pkg::PRD_W-1:0] r_wv [3];
    logic signed [psd_pkg::PRD_W-1:0] r_vv [3];
    logic signed [psd_pkg::DOT_W-1:0] r_c1, r_c2, n_c1, n_c2;
    psd_pkg::t_job       r_job, n_job;
    logic                w_en;
    logic signed [psd_pkg::CRD_W-1:0] p, a, b;

    assign w_en    = !r_v4 || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v4;
    assign o_job   = r_job;

    always_comb begin
        p = '0;
        a = '0;
        b = '0;
        for (int i = 0; i < 3; i++) begin
            p = $signed(i_data[i*psd_pkg::CRD_W +: psd_pkg::CRD_W]);
            a = $signed(i_data[(3+i)*psd_pkg::CRD_W +: psd_pkg::CRD_W]);
            b = $signed(i_data[(6+i)*psd_pkg::CRD_W +: psd_pkg::CRD_W]);
            n_v1d[i] = {b[psd_pkg::CRD_W-1], b} - {a[psd_pkg::CRD_W-1], a};
            n_w1[i]  = {p[psd_pkg::CRD_W-1], p} - {a[psd_pkg::CRD_W-1], a};
            n_u1[i]  = {p[psd_pkg::CRD_W-1], p} - {b[psd_pkg::CRD_W-1], b};
        end
    end

    always_comb begin
        n_c1 = '0;
        n_c2 = '0;
        for (int i = 0; i < 3; i++) begin
            n_c1 = n_c1 + psd_pkg::DOT_W'(r_wv[i]);
            n_c2 = n_c2 + psd_pkg::DOT_W'(r_vv[i]);
        end
    end

    always_comb begin
        n_job    = '0;
        n_job.c1 = r_c1;
        n_job.c2 = r_c2;
        n_job.w  = r_w3;
        n_job.v  = r_vd3;
        n_job.u  = r_u3;
        if (r_c1 <= 0) begin
            n_job.kind = psd_pkg::CASE_A;
        end else if (r_c2 <= r_c1) begin
            n_job.kind = psd_pkg::CASE_B;
        end else begin
            n_job.kind = psd_pkg::CASE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w1  <= n_w1;
            r_v1d <= n_v1d;
            r_u1  <= n_u1;
            for (int i = 0; i < 3; i++) begin
                r_wv[i] <= $signed(r_w1[i]) * $signed(r_v1d[i]);
                r_vv[i] <= $signed(r_v1d[i]) * $signed(r_v1d[i]);
            end
            r_w2  <= r_w1;
            r_vd2 <= r_v1d;
            r_u2  <= r_u1;
            r_c1  <= n_c1;
            r_c2  <= n_c2;
            r_w3  <= r_w2;
            r_vd3 <= r_vd2;
            r_u3  <= r_u2;
            r_job <= n_job;
        end
    end

endmodule

// File: design/psd_fifo.sv
// ----------------------------------------------------------------------------
// Point-segment distance job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "point_segment_distance_3d_core_defines.svh"

module psd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  psd_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output psd_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    psd_pkg::t_job   r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `PSD_AST_IMP(a_cnt_bound, 1'b1, r_count <= CW'(DEPTH), "queue count beyond depth")
    `PSD_AST_IMP(a_empty_ptr, r_count == '0, r_wr_ptr == r_rd_ptr, "empty queue, pointers apart")
    `PSD_AST_NXT(a_cnt_up, w_push && !w_pop, r_count == CW'($past(r_count) + 1'b1), "count missed a push")

endmodule

// File: design/psd_back.sv
// ----------------------------------------------------------------------------
// Point-segment distance back end
// Ratio divider, interior offset, squared length and root, all pipelined.
// ----------------------------------------------------------------------------
module psd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  psd_pkg::t_job                i_job,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [psd_pkg::DIST_W-1:0]   o_distance,
    output psd_pkg::t_case               o_case
);

    localparam int NDIV  = psd_pkg::RAT_W;
    localparam int NROOT = psd_pkg::ROOT_W;

    typedef struct packed {
        psd_pkg::t_case           kind;
        psd_pkg::t_vec            w;
        psd_pkg::t_vec            v;
        psd_pkg::t_vec            u;
        logic [psd_pkg::REM_W-1:0] rem;
        logic [psd_pkg::DEN_W-1:0] den;
        logic [psd_pkg::RAT_W-1:0] t;
    } t_dstg;

    typedef struct packed {
        psd_pkg::t_case             kind;
        logic [psd_pkg::SQS_W-1:0]  x;
        logic [psd_pkg::RR_W-1:0]   r;
        logic [psd_pkg::ROOT_W-1:0] q;
    } t_rstg;

    logic        w_en;
    logic        r_dvld [NDIV];
    t_dstg       r_div  [NDIV];
    t_dstg       n_div  [NDIV];
    logic        r_mvld, r_e1vld, r_e2vld, r_sqvld, r_sumvld, r_out_valid;
    logic        r_rvld [NROOT];
    t_rstg       r_rt   [NROOT];
    t_rstg       n_rt   [NROOT];

    psd_pkg::t_case r_mkind, r_e1kind, r_e2kind, r_sqkind, r_sumkind;
    psd_pkg::t_vec  r_mw, r_mu, r_e1w, r_e1u;
    logic signed [psd_pkg::PRD_W-1:0] r_prod [3];
    logic signed [psd_pkg::OFS_W-1:0] r_e [3];
    logic signed [psd_pkg::OFS_W-1:0] n_e [3];
    logic [psd_pkg::MAG_W-1:0] r_mag [3];
    logic [psd_pkg::MAG_W-1:0] n_mag [3];
    logic [psd_pkg::SQ_W-1:0]  r_sq  [3];
    logic [psd_pkg::SQS_W-1:0] r_sum, n_sum;
    logic [psd_pkg::DIST_W-1:0] r_dist;
    psd_pkg::t_case r_okind;

    logic [psd_pkg::REM_W:0]   sh;
    logic signed [psd_pkg::REM_W-1:0] full;
    logic signed [psd_pkg::OFS_W-1:0] sel;
    logic [psd_pkg::RR_W-1:0]  rr, trial;
    t_dstg                     src;
    t_rstg                     rsrc;

    assign w_en       = !r_out_valid || i_ready;
    assign o_ready    = w_en;
    assign o_valid    = r_out_valid;
    assign o_distance = r_dist;
    assign o_case     = r_okind;

    // restoring divide, one quotient bit per stage
    always_comb begin
        sh  = '0;
        src = '0;
        for (int k = 0; k < NDIV; k++) begin
            if (k == 0) begin
                src.kind = i_job.kind;
                src.w    = i_job.w;
                src.v    = i_job.v;
                src.u    = i_job.u;
                src.rem  = (i_job.kind == psd_pkg::CASE_MID) ?
                           i_job.c1[psd_pkg::REM_W-1:0] : '0;
                src.den  = i_job.c2[psd_pkg::DEN_W-1:0];
                src.t    = '0;
            end else begin
                src = r_div[k-1];
            end
            n_div[k] = src;
            sh = {src.rem, 1'b0};
            if (sh >= {2'b00, src.den}) begin
                n_div[k].rem = psd_pkg::REM_W'(sh - {2'b00, src.den});
                n_div[k].t   = {src.t[psd_pkg::RAT_W-2:0], 1'b1};
            end else begin
                n_div[k].rem = sh[psd_pkg::REM_W-1:0];
                n_div[k].t   = {src.t[psd_pkg::RAT_W-2:0], 1'b0};
            end
        end
    end

    // w*2^24 - t*v, rounded half up to 8 fractional bits
    always_comb begin
        full = '0;
        for (int i = 0; i < 3; i++) begin
            full = ($signed({r_mw[i], {psd_pkg::RAT_W{1'b0}}})
                    + $signed(psd_pkg::REM_W'(1) <<< (psd_pkg::RAT_W - 1)))
                   - psd_pkg::REM_W'(r_prod[i]);
            n_e[i] = full[psd_pkg::REM_W-1 -: psd_pkg::OFS_W];
        end
    end

    always_comb begin
        sel = '0;
        for (int i = 0; i < 3; i++) begin
            case (r_e1kind)
                psd_pkg::CASE_A:   sel = psd_pkg::OFS_W'($signed(r_e1w[i]));
                psd_pkg::CASE_B:   sel = psd_pkg::OFS_W'($signed(r_e1u[i]));
                default:           sel = r_e[i];
            endcase
            n_mag[i] = sel[psd_pkg::OFS_W-1] ? psd_pkg::MAG_W'(-sel) :
                                               psd_pkg::MAG_W'(sel);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 3; i++) begin
            n_sum = n_sum + psd_pkg::SQS_W'(r_sq[i]);
        end
    end

    // integer root, one result bit per stage
    always_comb begin
        rr    = '0;
        trial = '0;
        rsrc  = '0;
        for (int k = 0; k < NROOT; k++) begin
            if (k == 0) begin
                rsrc.kind = r_sumkind;
                rsrc.x    = r_sum;
                rsrc.r    = '0;
                rsrc.q    = '0;
            end else begin
                rsrc = r_rt[k-1];
            end
            n_rt[k]   = rsrc;
            n_rt[k].x = {rsrc.x[psd_pkg::SQS_W-3:0], 2'b00};
            rr    = {rsrc.r[psd_pkg::RR_W-3:0], rsrc.x[psd_pkg::SQS_W-1 -: 2]};
            trial = psd_pkg::RR_W'({rsrc.q, 2'b01});
            if (rr >= trial) begin
                n_rt[k].r = rr - trial;
                n_rt[k].q = {rsrc.q[psd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rt[k].r = rr;
                n_rt[k].q = {rsrc.q[psd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDIV; k++) begin
                r_dvld[k] <= 1'b0;
            end
            for (int k = 0; k < NROOT; k++) begin
                r_rvld[k] <= 1'b0;
            end
            r_mvld      <= 1'b0;
            r_e1vld     <= 1'b0;
            r_e2vld     <= 1'b0;
            r_sqvld     <= 1'b0;
            r_sumvld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_dvld[0] <= i_valid;
            for (int k = 1; k < NDIV; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
            r_mvld    <= r_dvld[NDIV-1];
            r_e1vld   <= r_mvld;
            r_e2vld   <= r_e1vld;
            r_sqvld   <= r_e2vld;
            r_sumvld  <= r_sqvld;
            r_rvld[0] <= r_sumvld;
            for (int k = 1; k < NROOT; k++) begin
                r_rvld[k] <= r_rvld[k-1];
            end
            r_out_valid <= r_rvld[NROOT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NDIV; k++) begin
                r_div[k] <= n_div[k];
            end
            r_mkind <= r_div[NDIV-1].kind;
            r_mw    <= r_div[NDIV-1].w;
            r_mu    <= r_div[NDIV-1].u;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= psd_pkg::PRD_W'($signed({1'b0, r_div[NDIV-1].t})
                                             * $signed(r_div[NDIV-1].v[i]));
                r_e[i]    <= n_e[i];
                r_mag[i]  <= n_mag[i];
                r_sq[i]   <= r_mag[i] * r_mag[i];
            end
            r_e1kind  <= r_mkind;
            r_e1w     <= r_mw;
            r_e1u     <= r_mu;
            r_e2kind  <= r_e1kind;
            r_sqkind  <= r_e2kind;
            r_sumkind <= r_sqkind;
            r_sum     <= n_sum;
            for (int k = 0; k < NROOT; k++) begin
                r_rt[k] <= n_rt[k];
            end
            r_okind <= r_rt[NROOT-1].kind;
            r_dist  <= (r_rt[NROOT-1].q[psd_pkg::ROOT_W-1:psd_pkg::DIST_W] != '0) ?
                       psd_pkg::DIST_MAX : r_rt[NROOT-1].q[psd_pkg::DIST_W-1:0];
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Point-segment distance core testbench
// Drives query/segment beats with random gaps and receiver stalls, predicts
// each distance and nearest-point case in fixed point, and checks every
// result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WDOG_LIMIT = 20000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [psd_pkg::IN_W-1:0]     i_s_tdata;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [psd_pkg::OUT_W-1:0]    o_m_tdata;
    logic [1:0]                   o_m_tuser;

    typedef struct packed {
        logic [psd_pkg::DIST_W-1:0] dval;
        psd_pkg::t_case             kind;
    } t_dist_res;

    t_dist_res   exp_q[$];
    int          fails;
    int          idle_cycles;
    bit          rx_hold;
    bit          rx_long;
    bit          hold_req;

    point_segment_distance_3d_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [psd_pkg::DIST_W-1:0] dist_from_sq(logic [63:0] sq);
        logic [63:0] d;
        d = isqrt(sq);
        return (d > 64'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX : d[psd_pkg::DIST_W-1:0];
    endfunction

    // Q32 -> Q8, ties toward plus infinity; arithmetic shift is floor
    function automatic longint rnd_q8(longint e);
        return (e + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic t_dist_res seg_distance(logic [psd_pkg::IN_W-1:0] d);
        longint p[3], a[3], b[3], v[3], w[3], e[3];
        longint c1, c2, rem, t;
        logic [63:0] sq;
        t_dist_res r;
        c1 = 0;
        c2 = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(d[i*psd_pkg::CRD_W +: psd_pkg::CRD_W]));
            a[i] = longint'($signed(d[(3+i)*psd_pkg::CRD_W +: psd_pkg::CRD_W]));
            b[i] = longint'($signed(d[(6+i)*psd_pkg::CRD_W +: psd_pkg::CRD_W]));
            v[i] = b[i] - a[i];
            w[i] = p[i] - a[i];
            c1 += w[i] * v[i];
            c2 += v[i] * v[i];
        end
        if (c1 <= 0) begin
            r.kind = psd_pkg::CASE_A;
            for (int i = 0; i < 3; i++) sq += 64'(w[i] * w[i]);
        end else if (c2 <= c1) begin
            r.kind = psd_pkg::CASE_B;
            for (int i = 0; i < 3; i++) sq += 64'((p[i] - b[i]) * (p[i] - b[i]));
        end else begin
            r.kind = psd_pkg::CASE_MID;
            rem = c1;
            t = 0;
            for (int i = 0; i < psd_pkg::RAT_W; i++) begin
                rem = rem <<< 1;
                t = t <<< 1;
                if (rem >= c2) begin
                    rem -= c2;
                    t |= 1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                e[i] = rnd_q8((w[i] <<< 24) - t * v[i]);
                sq += 64'(e[i] * e[i]);
            end
        end
        r.dval = dist_from_sq(sq);
        return r;
    endfunction

    task automatic send_query(logic [psd_pkg::IN_W-1:0] d, bit gaps);
        int g;
        t_dist_res want;
        g = 0;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) g = 0;
        end
        if (g != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        want = seg_distance(d);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk iff o_s_tready);
        exp_q = {exp_q, want};
    endtask

    function automatic logic [psd_pkg::IN_W-1:0] pack_pts(longint p[9]);
        logic [psd_pkg::IN_W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*psd_pkg::CRD_W +: psd_pkg::CRD_W] = p[i][psd_pkg::CRD_W-1:0];
        return d;
    endfunction

    function automatic longint rnd_crd(int span);
        case (span)
            0: return longint'($signed(24'($urandom)));
            1: return longint'($urandom_range(0, 2047)) - 1024;
            default: return longint'($urandom_range(0, 63)) - 32;
        endcase
    endfunction

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        longint pts[9];
        longint ext[4] = '{-8388608, 8388607, 0, -1};
        // degenerate segment
        pts = '{100, -200, 300, 5, 5, 5, 5, 5, 5};
        send_query(pack_pts(pts), 0);
        // nearest A, B, interior, exactly on end B, on the segment interior
        pts = '{-256, 0, 0, 0, 0, 0, 256, 0, 0};
        send_query(pack_pts(pts), 0);
        pts = '{512, 10, 0, 0, 0, 0, 256, 0, 0};
        send_query(pack_pts(pts), 0);
        pts = '{128, 256, -256, 0, 0, 0, 256, 0, 0};
        send_query(pack_pts(pts), 0);
        pts = '{256, 0, 0, 0, 0, 0, 256, 0, 0};
        send_query(pack_pts(pts), 0);
        pts = '{1, 1, 1, 0, 0, 0, 3, 3, 3};
        send_query(pack_pts(pts), 0);
        // corner extremes, incl. largest possible distance
        for (int k = 0; k < 16; k++) begin
            for (int i = 0; i < 9; i++) pts[i] = ext[(k + i * (k / 4 + 1)) % 4];
            send_query(pack_pts(pts), 0);
        end
        pts = '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                -8388608, -8388608, -8388608};
        send_query(pack_pts(pts), 0);
        pts = '{-8388608, 8388607, -8388608, -8388608, -8388608, -8388608,
                8388607, 8388607, 8388607};
        send_query(pack_pts(pts), 0);
    endtask

    task automatic test_random(int n);
        longint pts[9];
        int span;
        for (int k = 0; k < n; k++) begin
            span = $urandom_range(0, 2);
            for (int i = 0; i < 9; i++) pts[i] = rnd_crd(span);
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++) pts[6+i] = pts[3+i];
            send_query(pack_pts(pts), 1);
        end
    endtask

    task automatic test_backpressure();
        longint pts[9];
        hold_req = 1'b1;
        wait (rx_long);
        hold_req = 1'b0;
        for (int k = 0; k < 120; k++) begin
            for (int i = 0; i < 9; i++) pts[i] = rnd_crd(1);
            send_query(pack_pts(pts), 0);
        end
        wait_drained();
    endtask

    // receiver: random short stalls, long hold-offs come from rx_hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold) begin
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    // long receiver stall: count cycles in its own process
    initial begin
        int n;
        rx_hold = 1'b0;
        rx_long = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            n = 0;
            if (hold_req) begin
                n       = 300;
                rx_long = 1'b1;
            end else if ($urandom_range(0, 399) == 0) begin
                n = $urandom_range(50, 150);
            end
            if (n != 0) begin
                rx_hold = 1'b1;
                repeat (n) @(posedge i_clk);
                rx_hold = 1'b0;
                rx_long = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dist_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected beat dist=%0d case=%0d",
                         $time, o_m_tdata[psd_pkg::DIST_W-1:0], o_m_tuser);
                fails++;
            end else begin
                want = exp_q.pop_front();
                if (o_m_tdata[psd_pkg::DIST_W-1:0] !== want.dval) begin
                    $display("%0t: distance exp %0d got %0d",
                             $time, want.dval, o_m_tdata[psd_pkg::DIST_W-1:0]);
                    fails++;
                end
                if (o_m_tuser !== want.kind) begin
                    $display("%0t: case exp %0d got %0d", $time, want.kind, o_m_tuser);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (exp_q.size() == 0 && !i_s_tvalid)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_backpressure();
        test_random(230);
        wait_drained();
        test_random(230);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fails == 0 && exp_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
